// File: design/lbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and codes of the light blink classifier
// Class state encoding, report codes, register indexes and configuration
// bundle used by the classifier core and the register block.
// ----------------------------------------------------------------------------
package lbc_pkg;

	// Class state, held one-hot inside the core
	typedef enum logic [3:0] {
		ST_OFF     = 4'b0001,
		ST_BLINK   = 4'b0010,
		ST_ON      = 4'b0100,
		ST_UNKNOWN = 4'b1000
	} lbc_state_t;

	// Class codes as seen on the result channel
	localparam logic [1:0] CLS_OFF     = 2'd0;
	localparam logic [1:0] CLS_BLINK   = 2'd1;
	localparam logic [1:0] CLS_ON      = 2'd2;
	localparam logic [1:0] CLS_UNKNOWN = 2'd3;

	// Report codes
	localparam logic [2:0] RPT_OFF           = 3'd0;
	localparam logic [2:0] RPT_BLINK         = 3'd1;
	localparam logic [2:0] RPT_ON            = 3'd2;
	localparam logic [2:0] RPT_UNKNOWN       = 3'd3;
	localparam logic [2:0] RPT_TURNED_OFF    = 3'd4;
	localparam logic [2:0] RPT_TURNED_ON     = 3'd5;
	localparam logic [2:0] RPT_STARTED_BLINK = 3'd6;

	// Register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_THR  = 2'd1;

	// Register reset values
	localparam logic [31:0] HOLD_TIME_RST = 32'd5000;
	localparam logic [3:0]  BLINK_THR_RST = 4'd4;

	// Transition count ceiling
	localparam logic [3:0] COUNT_MAX = 4'd15;

	typedef struct packed {
		logic [31:0] hold_time_ms;
		logic [3:0]  blink_threshold;
	} lbc_cfg_t;

	// Map the one-hot state onto its external class code
	function automatic logic [1:0] class_code(input lbc_state_t st);
		logic [1:0] c;
		c = CLS_UNKNOWN;
		unique case (st)
			ST_OFF:     c = CLS_OFF;
			ST_BLINK:   c = CLS_BLINK;
			ST_ON:      c = CLS_ON;
			ST_UNKNOWN: c = CLS_UNKNOWN;
			default:    c = CLS_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

// File: design/light_blink_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_blink_classifier_unit: light level classifier, top level
// Input register, classifier core, result register and config registers.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  level, now_ms
//   out      source     out_valid/out_stall report_code, current_class
//   cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each item passes the
// input register, then the core, then the result register.
// The class state is updated as an item moves from the input register into
// the result register. Reset clears state and sets registers to defaults.
// A stalled result holds the input register, which then stalls the input.
// ----------------------------------------------------------------------------
module light_blink_classifier_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          level,
	input  logic [31:0]                   now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    report_code,
	output logic [1:0]                    current_class,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	lbc_pkg::lbc_cfg_t cfg;

	logic        valid_s1;
	logic        level_s1;
	logic [31:0] now_s1;
	logic        valid_s2;
	logic [2:0]  report_s2;
	logic [1:0]  class_s2;

	logic        advance;
	logic        accept;
	logic [2:0]  core_report;
	logic [1:0]  core_class;

	// Move an item on when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	lbc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lbc_classify u_classify (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.level         (level_s1),
		.now_ms        (now_s1),
		.cfg           (cfg),
		.report_code   (core_report),
		.current_class (core_class)
	);

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= level;
			now_s1   <= now_ms;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			report_s2 <= core_report;
			class_s2  <= core_class;
		end
	end

	assign out_valid     = valid_s2;
	assign report_code   = report_s2;
	assign current_class = class_s2;

	// Stall is only raised with an item waiting in the input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// A new result comes only from an item in the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result appeared without a source item");

	// A blocked result register with a waiting item must stall the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |-> in_stall)
		else $error("input not stalled while both stages are full");

endmodule

// File: design/lbc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_cfg_regs: configuration registers
// Holds the hold time and blink threshold; takes one write per cycle.
// ----------------------------------------------------------------------------
module lbc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output lbc_pkg::lbc_cfg_t             cfg
);

	logic [31:0] hold_time_q;
	logic [3:0]  blink_thr_q;

	// Always ready for a write
	assign cfg_ready = 1'b1;

	// Decode the index; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= lbc_pkg::HOLD_TIME_RST;
			blink_thr_q <= lbc_pkg::BLINK_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == lbc_pkg::CFG_HOLD_TIME) begin
				hold_time_q <= cfg_data;
			end else if (cfg_index == lbc_pkg::CFG_BLINK_THR) begin
				blink_thr_q <= cfg_data[3:0];
			end
		end
	end

	assign cfg.hold_time_ms    = hold_time_q;
	assign cfg.blink_threshold = blink_thr_q;

endmodule

// File: design/lbc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_classify: classifier state and next-state logic
// One subtract, the hold and count compares and the class update for one item; the state
// registers advance when step is high.
// ----------------------------------------------------------------------------
module lbc_classify (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              level,
	input  logic [31:0]       now_ms,
	input  lbc_pkg::lbc_cfg_t cfg,
	output logic [2:0]        report_code,
	output logic [1:0]        current_class
);

	lbc_pkg::lbc_state_t state_q, state_d;
	lbc_pkg::lbc_state_t before_q, before_d;
	logic [31:0] edge_time_q, edge_time_d;
	logic [3:0]  edge_count_q, edge_count_d;
	logic        level_q, level_d;

	logic [31:0] elapsed;
	logic        held;
	logic [3:0]  count_inc;
	logic [2:0]  code;

	// Work out the elapsed time and the next class
	always_comb begin
		elapsed   = now_ms - edge_time_q;
		held      = (elapsed >= cfg.hold_time_ms);
		count_inc = (edge_count_q == lbc_pkg::COUNT_MAX) ? lbc_pkg::COUNT_MAX
		                                                  : edge_count_q + 4'd1;
		state_d      = state_q;
		before_d     = before_q;
		edge_time_d  = edge_time_q;
		edge_count_d = edge_count_q;
		level_d      = level_q;
		code         = lbc_pkg::RPT_UNKNOWN;

		unique case (state_q)
			lbc_pkg::ST_ON, lbc_pkg::ST_OFF: begin
				code = {1'b0, lbc_pkg::class_code(state_q)};
				if (level != (state_q == lbc_pkg::ST_ON)) begin
					before_d     = state_q;
					state_d      = lbc_pkg::ST_UNKNOWN;
					edge_time_d  = now_ms;
					edge_count_d = 4'd1;
					level_d      = level;
				end
			end
			lbc_pkg::ST_BLINK: begin
				if ((level != level_q) && !held) begin
					level_d      = level;
					edge_count_d = count_inc;
					edge_time_d  = now_ms;
					code         = lbc_pkg::RPT_BLINK;
				end else if (held) begin
					// Settle to the steady level
					before_d     = lbc_pkg::ST_BLINK;
					state_d      = level ? lbc_pkg::ST_ON : lbc_pkg::ST_OFF;
					edge_count_d = 4'd1;
					level_d      = level;
					edge_time_d  = now_ms;
					code         = level ? lbc_pkg::RPT_TURNED_ON : lbc_pkg::RPT_TURNED_OFF;
				end else begin
					code = lbc_pkg::RPT_BLINK;
				end
			end
			lbc_pkg::ST_UNKNOWN: begin
				if (held) begin
					// Settle, leaving the previous class alone
					state_d      = level ? lbc_pkg::ST_ON : lbc_pkg::ST_OFF;
					edge_count_d = 4'd1;
					level_d      = level;
					edge_time_d  = now_ms;
					code         = level ? lbc_pkg::RPT_TURNED_ON : lbc_pkg::RPT_TURNED_OFF;
				end else if (level == level_q) begin
					code = {1'b0, lbc_pkg::class_code(before_q)};
				end else begin
					edge_count_d = count_inc;
					level_d      = level;
					edge_time_d  = now_ms;
					if (count_inc >= cfg.blink_threshold) begin
						before_d = lbc_pkg::ST_UNKNOWN;
						state_d  = lbc_pkg::ST_BLINK;
						code     = lbc_pkg::RPT_STARTED_BLINK;
					end else begin
						code = {1'b0, lbc_pkg::class_code(before_q)};
					end
				end
			end
			default: begin
				state_d = lbc_pkg::ST_UNKNOWN;
			end
		endcase
	end

	assign report_code   = code;
	assign current_class = lbc_pkg::class_code(state_d);

	// Advance the class state on each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lbc_pkg::ST_UNKNOWN;
			before_q     <= lbc_pkg::ST_UNKNOWN;
			edge_time_q  <= 32'd0;
			edge_count_q <= 4'd0;
			level_q      <= 1'b0;
		end else if (step) begin
			state_q      <= state_d;
			before_q     <= before_d;
			edge_time_q  <= edge_time_d;
			edge_count_q <= edge_count_d;
			level_q      <= level_d;
		end
	end

	// A zero count only exists before the first settle or transition
	a_zero_count_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		(edge_count_q == 4'd0) |->
		(state_q == lbc_pkg::ST_UNKNOWN && before_q == lbc_pkg::ST_UNKNOWN))
		else $error("edge count zero after class left reset state");

	// A steady class always restarted the count at one
	a_steady_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lbc_pkg::ST_ON || state_q == lbc_pkg::ST_OFF) |->
		(edge_count_q == 4'd1))
		else $error("steady class with count other than one");

	// Started blinking always lands in the blinking class
	a_start_blink: assert property (@(posedge clk) disable iff (!arst_n)
		(step && code == lbc_pkg::RPT_STARTED_BLINK) |=>
		(state_q == lbc_pkg::ST_BLINK && before_q == lbc_pkg::ST_UNKNOWN))
		else $error("started blinking without entering blinking class");

endmodule
